// File: hw/rtl/tepq_pkg.sv
// shared types, codes and the time-left helper of the timer event queue
`timescale 1ns / 1ps

package tepq_pkg;

    localparam int TAG_W  = 8;
    localparam int TICK_W = 16;
    localparam int TMO_W  = 15;
    localparam int TL_W   = 18;

    // operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_POP    = 1'b1;

    // status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // timer action codes
    localparam logic [1:0] ACT_LEAVE  = 2'd0;
    localparam logic [1:0] ACT_RELOAD = 2'd1;
    localparam logic [1:0] ACT_OFF    = 2'd2;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [TICK_W-1:0] created;
        logic [TMO_W-1:0]  tmo;
    } t_entry;

    typedef struct packed {
        logic              func;
        logic [TICK_W-1:0] now;
        logic [TMO_W-1:0]  timeout;
        logic [TAG_W-1:0]  tag;
    } t_in_item;

    typedef struct packed {
        logic [TAG_W-1:0]  popped_tag;
        logic              popped_valid;
        logic [1:0]        status;
        logic [1:0]        timer_action;
        logic [TICK_W-1:0] head_time_left;
        logic              head_due;
    } t_out_item;

    // read and write strobes toward the level cells
    typedef struct packed {
        logic   rd;
        logic   wr;
        t_entry wr_data;
    } t_cell_req;

    // twice the timeout minus the wrapped ticks elapsed since creation
    function automatic logic signed [TL_W-1:0] time_left(
        input t_entry            e,
        input logic [TICK_W-1:0] now
    );
        logic [TICK_W-1:0] el;
        el = now - e.created;
        time_left = $signed({2'b00, e.tmo, 1'b0}) - $signed({2'b00, el});
    endfunction

endpackage

// File: hw/rtl/tepq_if.sv
// request and response channel interfaces of the timer event queue
`timescale 1ns / 1ps

interface tepq_in_if;
    logic                valid;
    logic                ready;
    tepq_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tepq_out_if;
    logic                valid;
    logic                ready;
    tepq_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/tepq_cell.sv
// one heap level: its own entry storage and a stage of the read-data chain
`timescale 1ns / 1ps

module tepq_cell #(
    parameter int DEPTH = 16,
    parameter int LEVEL = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tepq_pkg::t_cell_req             i_req,
    input  logic [$clog2($clog2(DEPTH+1)+1)-1:0] i_rd_lvl,
    input  logic [$clog2(DEPTH+1)-2:0]      i_rd_off,
    input  logic [$clog2($clog2(DEPTH+1)+1)-1:0] i_wr_lvl,
    input  logic [$clog2(DEPTH+1)-2:0]      i_wr_off,
    input  tepq_pkg::t_entry                i_chain,
    output tepq_pkg::t_entry                o_chain
);

    localparam int NLEV    = $clog2(DEPTH + 1);
    localparam int LVL_W   = $clog2(NLEV + 1);
    localparam int SPAN    = 1 << LEVEL;
    localparam int L_DEPTH = (SPAN < DEPTH + 1 - SPAN) ? SPAN : DEPTH + 1 - SPAN;
    localparam int A_W     = (L_DEPTH > 1) ? $clog2(L_DEPTH) : 1;

    tepq_pkg::t_entry r_mem [L_DEPTH];
    tepq_pkg::t_entry r_rd_data;
    logic             r_rd_hit;
    logic             rd_sel;
    logic             wr_sel;

    // level decode
    assign rd_sel = i_req.rd && (i_rd_lvl == LVL_W'(LEVEL));
    assign wr_sel = i_req.wr && (i_wr_lvl == LVL_W'(LEVEL));

    // level storage, registered read
    always_ff @(posedge i_clk) begin
        if (wr_sel) begin
            r_mem[i_wr_off[A_W-1:0]] <= i_req.wr_data;
        end
        if (rd_sel) begin
            r_rd_data <= r_mem[i_rd_off[A_W-1:0]];
        end
    end

    // marks the cycle in which this level owns the read chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_hit <= 1'b0;
        end else begin
            r_rd_hit <= rd_sel;
        end
    end

    // read chain: pass the neighbor's data unless this level answered
    assign o_chain = r_rd_hit ? r_rd_data : i_chain;

endmodule

// File: hw/rtl/timer_event_priority_queue.sv
// timer event priority queue: binary min-heap held as a chain of level cells
// insert: written straight in when the queue is empty, dropped when it is full; otherwise the
//   event climbs one level at a time while strictly earlier than its parent, then is written
// pop: refills the root from the last entry unless at most one event is held, then walks down
//   level by level, reading the left and, where it exists, the right child from one cell port
// one request at a time; the result register lets the next request in while a result waits
// reset clears the count and control; entry storage is not cleared and needs no sweep
`timescale 1ns / 1ps

module timer_event_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tepq_in_if.sink           i_req,
    tepq_out_if.source        o_rsp
);

    localparam int NLEV   = $clog2(DEPTH + 1);
    localparam int LVL_W  = $clog2(NLEV + 1);
    localparam int OFF_W  = NLEV - 1;
    localparam int OFFX_W = OFF_W + 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_UP   = 7'b0000010,
        S_LAST = 7'b0000100,
        S_DN_L = 7'b0001000,
        S_DN_R = 7'b0010000,
        S_PUT  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state                       r_state, n_state;
    logic                         r_func, n_func;
    logic [tepq_pkg::TICK_W-1:0]  r_now, n_now;
    tepq_pkg::t_entry             r_x, n_x;
    tepq_pkg::t_entry             r_bd, n_bd;
    logic                         r_bsel, n_bsel;
    tepq_pkg::t_entry             r_head;
    logic [LVL_W-1:0]             r_lvl, n_lvl;
    logic [OFF_W-1:0]             r_off, n_off;
    logic [LVL_W-1:0]             r_tail_lvl, n_tail_lvl;
    logic [OFF_W-1:0]             r_tail_off, n_tail_off;
    logic [CNT_W-1:0]             r_count, n_count;
    logic [1:0]                   r_status, n_status;
    logic [1:0]                   r_ins_act, n_ins_act;
    logic [tepq_pkg::TAG_W-1:0]   r_pop_tag, n_pop_tag;
    logic                         r_pop_valid, n_pop_valid;
    logic                         r_out_valid, n_out_valid;
    tepq_pkg::t_out_item          r_out, n_out;

    tepq_pkg::t_cell_req          cell_req;
    logic [LVL_W-1:0]             rd_lvl, wr_lvl;
    logic [OFF_W-1:0]             rd_off, wr_off;
    tepq_pkg::t_entry             chain [NLEV+1];
    tepq_pkg::t_entry             rd_data;
    tepq_pkg::t_entry             in_entry;

    logic signed [tepq_pkg::TL_W-1:0] tl_x, tl_d, tl_b, tl_head;
    logic [OFFX_W-1:0]            inc_off, inc_span, dec_span;
    logic                         right_ok;
    logic                         res_sel, res_right;
    tepq_pkg::t_entry             res_data;
    logic                         do_resolve;
    logic [OFF_W-1:0]             c_off;
    logic                         head_empty, head_due;
    tepq_pkg::t_out_item          report;

    // a child slot exists when it lies before the tail position
    function automatic logic kid_ok(
        input logic [LVL_W-1:0]  cl,
        input logic [OFFX_W-1:0] co,
        input logic [LVL_W-1:0]  tail_l,
        input logic [OFF_W-1:0]  tail_o
    );
        kid_ok = (cl < tail_l) || ((cl == tail_l) && (co < {1'b0, tail_o}));
    endfunction

    // chain of level cells
    assign chain[0] = '0;
    for (genvar g = 0; g < NLEV; g++) begin : g_level
        tepq_cell #(
            .DEPTH (DEPTH),
            .LEVEL (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_req    (cell_req),
            .i_rd_lvl (rd_lvl),
            .i_rd_off (rd_off),
            .i_wr_lvl (wr_lvl),
            .i_wr_off (wr_off),
            .i_chain  (chain[g]),
            .o_chain  (chain[g+1])
        );
    end
    assign rd_data = chain[NLEV];

    assign in_entry = '{tag: i_req.data.tag, created: i_req.data.now,
                        tmo: i_req.data.timeout};

    // comparison keys at the tick of the current request
    assign tl_x    = tepq_pkg::time_left(r_x, r_now);
    assign tl_d    = tepq_pkg::time_left(rd_data, r_now);
    assign tl_b    = tepq_pkg::time_left(r_bd, r_now);
    assign tl_head = tepq_pkg::time_left(r_head, r_now);

    // tail position stepping forward and back
    assign inc_off  = {1'b0, r_tail_off} + 1'b1;
    assign inc_span = OFFX_W'(1) << r_tail_lvl;
    assign dec_span = OFFX_W'(1) << (r_tail_lvl - LVL_W'(1));

    // right child of the current slot
    assign right_ok = kid_ok(r_lvl + LVL_W'(1), {r_off, 1'b1}, r_tail_lvl, r_tail_off);

    // winner of a sift-down level
    always_comb begin
        res_sel   = 1'b0;
        res_right = 1'b0;
        res_data  = r_bd;
        if (r_state == S_DN_L) begin
            res_sel  = (tl_d < tl_x);
            res_data = rd_data;
        end else if (tl_d < (r_bsel ? tl_b : tl_x)) begin
            res_sel   = 1'b1;
            res_right = 1'b1;
            res_data  = rd_data;
        end else begin
            res_sel = r_bsel;
        end
    end

    assign do_resolve = ((r_state == S_DN_L) && !right_ok) || (r_state == S_DN_R);
    assign c_off      = OFF_W'({r_off, res_right});

    // head report after the operation
    assign head_empty = (r_count == '0);
    assign head_due   = !head_empty && tl_head[tepq_pkg::TL_W-1];
    always_comb begin
        report.popped_tag     = r_pop_tag;
        report.popped_valid   = r_pop_valid;
        report.status         = r_status;
        report.head_due       = head_due;
        report.head_time_left = (head_empty || head_due) ? '0
                                : tl_head[tepq_pkg::TICK_W-1:0];
        if (r_func == tepq_pkg::FUNC_INSERT) begin
            report.timer_action = r_ins_act;
        end else if (head_empty) begin
            report.timer_action = tepq_pkg::ACT_OFF;
        end else if (head_due) begin
            report.timer_action = tepq_pkg::ACT_LEAVE;
        end else begin
            report.timer_action = tepq_pkg::ACT_RELOAD;
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_now       = r_now;
        n_x         = r_x;
        n_bd        = r_bd;
        n_bsel      = r_bsel;
        n_lvl       = r_lvl;
        n_off       = r_off;
        n_tail_lvl  = r_tail_lvl;
        n_tail_off  = r_tail_off;
        n_count     = r_count;
        n_status    = r_status;
        n_ins_act   = r_ins_act;
        n_pop_tag   = r_pop_tag;
        n_pop_valid = r_pop_valid;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        cell_req.rd      = 1'b0;
        cell_req.wr      = 1'b0;
        cell_req.wr_data = r_x;
        rd_lvl = '0;
        rd_off = '0;
        wr_lvl = r_lvl;
        wr_off = r_off;

        // result register drains independently of the work
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_func      = i_req.data.func;
                    n_now       = i_req.data.now;
                    n_x         = in_entry;
                    n_status    = tepq_pkg::STATUS_OK;
                    n_ins_act   = tepq_pkg::ACT_LEAVE;
                    n_pop_tag   = '0;
                    n_pop_valid = 1'b0;
                    n_state     = S_DONE;
                    if (i_req.data.func == tepq_pkg::FUNC_INSERT) begin
                        if (r_count == CNT_W'(DEPTH)) begin
                            n_status = tepq_pkg::STATUS_FULL;
                        end else begin
                            n_count = r_count + 1'b1;
                            n_lvl   = r_tail_lvl;
                            n_off   = r_tail_off;
                            if (inc_off == inc_span) begin
                                n_tail_lvl = r_tail_lvl + LVL_W'(1);
                                n_tail_off = '0;
                            end else begin
                                n_tail_off = inc_off[OFF_W-1:0];
                            end
                            if (r_tail_lvl == '0) begin
                                // empty queue: the event becomes the root
                                cell_req.wr      = 1'b1;
                                cell_req.wr_data = in_entry;
                                wr_lvl           = '0;
                                wr_off           = '0;
                                n_ins_act        = tepq_pkg::ACT_RELOAD;
                            end else begin
                                cell_req.rd = 1'b1;
                                rd_lvl      = r_tail_lvl - LVL_W'(1);
                                rd_off      = r_tail_off >> 1;
                                n_state     = S_UP;
                            end
                        end
                    end else if (r_count == '0) begin
                        n_status = tepq_pkg::STATUS_EMPTY;
                    end else begin
                        n_pop_tag   = r_head.tag;
                        n_pop_valid = 1'b1;
                        n_count     = r_count - 1'b1;
                        if (r_tail_off == '0) begin
                            n_tail_lvl = r_tail_lvl - LVL_W'(1);
                            n_tail_off = OFF_W'(dec_span - 1'b1);
                        end else begin
                            n_tail_off = r_tail_off - 1'b1;
                        end
                        if (r_count != CNT_W'(1)) begin
                            // fetch the last entry to refill the root
                            cell_req.rd = 1'b1;
                            rd_lvl      = n_tail_lvl;
                            rd_off      = n_tail_off;
                            n_state     = S_LAST;
                        end
                    end
                end
            end
            S_UP: begin
                if (tl_x < tl_d) begin
                    // parent moves down, event climbs one level
                    cell_req.wr      = 1'b1;
                    cell_req.wr_data = rd_data;
                    n_lvl = r_lvl - LVL_W'(1);
                    n_off = r_off >> 1;
                    if (r_lvl == LVL_W'(1)) begin
                        n_ins_act = tepq_pkg::ACT_RELOAD;
                        n_state   = S_PUT;
                    end else begin
                        cell_req.rd = 1'b1;
                        rd_lvl      = r_lvl - LVL_W'(2);
                        rd_off      = r_off >> 2;
                    end
                end else begin
                    cell_req.wr = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_LAST: begin
                n_x   = rd_data;
                n_lvl = '0;
                n_off = '0;
                if (r_count > CNT_W'(1)) begin
                    cell_req.rd = 1'b1;
                    rd_lvl      = LVL_W'(1);
                    rd_off      = '0;
                    n_state     = S_DN_L;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_DN_L: begin
                n_bd   = rd_data;
                n_bsel = (tl_d < tl_x);
                if (right_ok) begin
                    cell_req.rd = 1'b1;
                    rd_lvl      = r_lvl + LVL_W'(1);
                    rd_off      = OFF_W'({r_off, 1'b1});
                    n_state     = S_DN_R;
                end
            end
            S_DN_R: begin
                n_state = r_state;
            end
            S_PUT: begin
                cell_req.wr = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out       = report;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // close one sift-down level
        if (do_resolve) begin
            cell_req.wr = 1'b1;
            if (!res_sel) begin
                n_state = S_DONE;
            end else begin
                cell_req.wr_data = res_data;
                n_lvl = r_lvl + LVL_W'(1);
                n_off = c_off;
                if (kid_ok(r_lvl + LVL_W'(2), {c_off, 1'b0}, r_tail_lvl, r_tail_off)) begin
                    cell_req.rd = 1'b1;
                    rd_lvl      = r_lvl + LVL_W'(2);
                    rd_off      = OFF_W'({c_off, 1'b0});
                    n_state     = S_DN_L;
                end else begin
                    n_state = S_PUT;
                end
            end
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_tail_lvl  <= '0;
            r_tail_off  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_tail_lvl  <= n_tail_lvl;
            r_tail_off  <= n_tail_off;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_now       <= n_now;
        r_x         <= n_x;
        r_bd        <= n_bd;
        r_bsel      <= n_bsel;
        r_lvl       <= n_lvl;
        r_off       <= n_off;
        r_status    <= n_status;
        r_ins_act   <= n_ins_act;
        r_pop_tag   <= n_pop_tag;
        r_pop_valid <= n_pop_valid;
        r_out       <= n_out;
        // shadow of the root entry
        if (cell_req.wr && (wr_lvl == '0)) begin
            r_head <= cell_req.wr_data;
        end
    end

    // fill level never passes the capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("event count above capacity");

    // an empty heap has its tail at the root slot
    a_tail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> ((r_tail_lvl == '0) && (r_tail_off == '0)))
        else $error("tail position out of step with count");

    // an accepted insert into a non-full queue grows it by one
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && (i_req.data.func == tepq_pkg::FUNC_INSERT)
         && (r_count != CNT_W'(DEPTH)))
        |=> (r_count == CNT_W'($past(r_count) + 1'b1)))
        else $error("insert did not grow the queue");

    // an accepted pop from a non-empty queue shrinks it by one
    a_pop_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && (i_req.data.func == tepq_pkg::FUNC_POP)
         && (r_count != '0))
        |=> (r_count == CNT_W'($past(r_count) - 1'b1)))
        else $error("pop did not shrink the queue");

endmodule

// File: sim/tepq_checker.sv
// checker for the timer event queue: heap predictor and per-field result comparison
`timescale 1ns / 1ps

module tepq_checker #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic                i_req_ready,
    input  tepq_pkg::t_in_item  i_req_data,
    input  logic                i_rsp_valid,
    input  logic                i_rsp_ready,
    input  tepq_pkg::t_out_item i_rsp_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    tepq_pkg::t_entry    heap_slot [DEPTH];
    int                  heap_fill;
    tepq_pkg::t_out_item expected_rsp_q [$];
    tepq_pkg::t_out_item want;
    int                  failures;
    int                  rsp_seen;

    // signed ticks before an entry is due, elapsed time wraps at 16 bits
    function automatic int ticks_left(input tepq_pkg::t_entry e, input logic [15:0] now);
        logic [15:0] elapsed;
        elapsed = now - e.created;
        return 2 * int'(e.tmo) - int'(elapsed);
    endfunction

    function automatic void swap_slots(input int a, input int b);
        tepq_pkg::t_entry hold;
        hold         = heap_slot[a];
        heap_slot[a] = heap_slot[b];
        heap_slot[b] = hold;
    endfunction

    // apply one request to the heap and build the result it should give
    function automatic tepq_pkg::t_out_item apply_request(input tepq_pkg::t_in_item rq);
        tepq_pkg::t_out_item r;
        int                  idx;
        int                  kid;
        int                  best;
        int                  head_left;
        bit                  sinking;
        r = '0;
        if (rq.func == tepq_pkg::FUNC_INSERT) begin
            if (heap_fill >= DEPTH) begin
                r.status       = tepq_pkg::STATUS_FULL;
                r.timer_action = tepq_pkg::ACT_LEAVE;
            end else begin
                idx = heap_fill;
                heap_slot[idx].tag     = rq.tag;
                heap_slot[idx].created = rq.now;
                heap_slot[idx].tmo     = rq.timeout;
                heap_fill++;
                // climb while strictly earlier than the parent
                while (idx > 0 && ticks_left(heap_slot[idx], rq.now) <
                       ticks_left(heap_slot[(idx - 1) / 2], rq.now)) begin
                    swap_slots(idx, (idx - 1) / 2);
                    idx = (idx - 1) / 2;
                end
                r.timer_action = (idx == 0) ? tepq_pkg::ACT_RELOAD : tepq_pkg::ACT_LEAVE;
            end
        end else if (heap_fill == 0) begin
            r.status       = tepq_pkg::STATUS_EMPTY;
            r.timer_action = tepq_pkg::ACT_OFF;
        end else begin
            r.popped_tag   = heap_slot[0].tag;
            r.popped_valid = 1'b1;
            heap_fill--;
            if (heap_fill > 0) begin
                heap_slot[0] = heap_slot[heap_fill];
                idx     = 0;
                sinking = 1'b1;
                // sink the moved entry, left child first, right against the better one
                while (sinking) begin
                    best = idx;
                    kid  = 2 * idx + 1;
                    if (kid < heap_fill && ticks_left(heap_slot[kid], rq.now) <
                        ticks_left(heap_slot[best], rq.now))
                        best = kid;
                    if (kid + 1 < heap_fill && ticks_left(heap_slot[kid + 1], rq.now) <
                        ticks_left(heap_slot[best], rq.now))
                        best = kid + 1;
                    if (best == idx) begin
                        sinking = 1'b0;
                    end else begin
                        swap_slots(idx, best);
                        idx = best;
                    end
                end
            end
        end
        // head report after the operation
        if (heap_fill > 0) begin
            head_left        = ticks_left(heap_slot[0], rq.now);
            r.head_due       = (head_left < 0);
            r.head_time_left = (head_left < 0) ? 16'd0 : head_left[15:0];
        end
        if (r.popped_valid) begin
            if (heap_fill == 0)
                r.timer_action = tepq_pkg::ACT_OFF;
            else
                r.timer_action = r.head_due ? tepq_pkg::ACT_LEAVE : tepq_pkg::ACT_RELOAD;
        end
        return r;
    endfunction

    task automatic check_field(input string label, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            failures++;
            if (failures <= 10)
                $display("result %0d: %s expected %0d, got %0d", rsp_seen, label,
                         want_v, got_v);
        end
    endtask

    // compare finished results first, then predict the newly accepted request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            heap_fill = 0;
            expected_rsp_q.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                rsp_seen++;
                if (expected_rsp_q.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("result %0d: arrived with no request outstanding",
                                 rsp_seen);
                end else begin
                    want = expected_rsp_q.pop_front();
                    check_field("popped_tag", 16'(want.popped_tag),
                                16'(i_rsp_data.popped_tag));
                    check_field("popped_valid", 16'(want.popped_valid),
                                16'(i_rsp_data.popped_valid));
                    check_field("status", 16'(want.status), 16'(i_rsp_data.status));
                    check_field("timer_action", 16'(want.timer_action),
                                16'(i_rsp_data.timer_action));
                    check_field("head_time_left", want.head_time_left,
                                i_rsp_data.head_time_left);
                    check_field("head_due", 16'(want.head_due), 16'(i_rsp_data.head_due));
                end
            end
            if (i_req_valid && i_req_ready)
                expected_rsp_q.push_back(apply_request(i_req_data));
        end
        o_pending    <= expected_rsp_q.size();
        o_fail_count <= failures;
    end

endmodule

// File: sim/timer_event_priority_queue_tb.sv
// testbench top of the timer event queue: clock, reset, request stimulus, back-pressure, verdict
`timescale 1ns / 1ps

module timer_event_priority_queue_tb;

    localparam int DEPTH        = 16;
    localparam int N_RANDOM     = 1075;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tepq_in_if  req_ch ();
    tepq_out_if rsp_ch ();

    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   take_idle_pct;
    int   hold_left;
    int   cycles;
    logic hold_go   = 1'b0;
    logic hold_done = 1'b0;

    always #5 i_clk = ~i_clk;

    timer_event_priority_queue #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    tepq_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_ch.valid),
        .i_req_ready  (req_ch.ready),
        .i_req_data   (req_ch.data),
        .i_rsp_valid  (rsp_ch.valid),
        .i_rsp_ready  (rsp_ch.ready),
        .i_rsp_data   (rsp_ch.data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result side: random back-pressure plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_done    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timer_event_priority_queue regression: fail");
            $finish;
        end
    end

    // offer one request and hold it until accepted
    task automatic issue(input logic fn, input logic [15:0] now, input logic [14:0] tmo,
                         input logic [7:0] tag);
        tepq_pkg::t_in_item rq;
        rq.func    = fn;
        rq.now     = now;
        rq.timeout = tmo;
        rq.tag     = tag;
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= rq;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // stop offering until every outstanding result has come back
    task automatic drain();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        logic [15:0] tick;
        logic [14:0] tmo;
        logic        fn;
        int          insert_pct;
        i_rst_n       <= 1'b0;
        req_ch.valid  <= 1'b0;
        req_ch.data   <= '0;
        take_idle_pct <= 81;
        send_idle_pct = 36;
        insert_pct    = 60;
        tick          = 16'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pop on empty, then fill to capacity with extreme values
        issue(tepq_pkg::FUNC_POP, 16'd0, 15'd0, 8'd0);
        issue(tepq_pkg::FUNC_INSERT, 16'hFFFF, 15'h7FFF, 8'hFF);
        issue(tepq_pkg::FUNC_INSERT, 16'd1000, 15'd0, 8'd0);
        issue(tepq_pkg::FUNC_INSERT, 16'd1000, 15'd3, 8'd1);
        issue(tepq_pkg::FUNC_INSERT, 16'd1000, 15'd5, 8'd2);
        issue(tepq_pkg::FUNC_INSERT, 16'd1000, 15'd10, 8'd3);
        issue(tepq_pkg::FUNC_INSERT, 16'd1000, 15'd20, 8'd4);
        issue(tepq_pkg::FUNC_INSERT, 16'd1000, 15'd200, 8'd5);
        issue(tepq_pkg::FUNC_INSERT, 16'd1000, 15'd7, 8'd6);
        issue(tepq_pkg::FUNC_INSERT, 16'd1000, 15'h7FFF, 8'd7);
        issue(tepq_pkg::FUNC_INSERT, 16'd1000, 15'd4000, 8'd8);
        issue(tepq_pkg::FUNC_INSERT, 16'd1000, 15'd12, 8'd9);
        issue(tepq_pkg::FUNC_INSERT, 16'd1000, 15'd9, 8'd10);
        issue(tepq_pkg::FUNC_INSERT, 16'd1000, 15'd100, 8'd11);
        issue(tepq_pkg::FUNC_INSERT, 16'd1000, 15'd6, 8'd12);
        issue(tepq_pkg::FUNC_INSERT, 16'd1000, 15'd50, 8'd13);
        issue(tepq_pkg::FUNC_INSERT, 16'd1000, 15'd30000, 8'd14);
        // pops: new head exactly due, then overdue, then after a wrap
        issue(tepq_pkg::FUNC_POP, 16'd1006, 15'd0, 8'd0);
        issue(tepq_pkg::FUNC_POP, 16'd1020, 15'd0, 8'd0);
        issue(tepq_pkg::FUNC_POP, 16'd1020, 15'd0, 8'd0);
        issue(tepq_pkg::FUNC_POP, 16'hFFFF, 15'd0, 8'd0);
        issue(tepq_pkg::FUNC_INSERT, 16'd3000, 15'h7FFF, 8'hA5);
        issue(tepq_pkg::FUNC_POP, 16'd0, 15'd0, 8'd0);

        // random mix, insert bias changes so the heap both fills and empties
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM / 3) begin
                drain();
                send_idle_pct = 81;
                take_idle_pct <= 36;
            end
            if (k == 2 * N_RANDOM / 3) begin
                send_idle_pct = 0;
                take_idle_pct <= 0;
                hold_go       <= 1'b1;
                insert_pct    = 90;
            end else if (k % 40 == 0) begin
                case ($urandom_range(3))
                    0:       insert_pct = 25;
                    1:       insert_pct = 50;
                    2:       insert_pct = 70;
                    default: insert_pct = 90;
                endcase
            end
            if ($urandom_range(19) == 0)
                tick = 16'($urandom_range(65535));
            else
                tick = tick + 16'($urandom_range(30));
            case ($urandom_range(9))
                0:       tmo = $urandom_range(1) ? 15'h7FFF : 15'd0;
                1, 2:    tmo = 15'($urandom_range(32767));
                3, 4, 5: tmo = 15'($urandom_range(2000));
                default: tmo = 15'($urandom_range(40));
            endcase
            fn = ($urandom_range(99) < insert_pct) ? tepq_pkg::FUNC_INSERT
                                                   : tepq_pkg::FUNC_POP;
            issue(fn, tick, tmo, 8'($urandom_range(255)));
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("timer_event_priority_queue regression: pass");
        else
            $display("timer_event_priority_queue regression: fail");
        $finish;
    end

endmodule
